// File: hw/rtl/dlpg_pkg.sv
// ----------------------------------------------------------------------------
// DDA line pixel generator package
// Shared constants, payload types, controller states and the command and
// status groups between the controller and the datapath.
// ----------------------------------------------------------------------------
package dlpg_pkg;

  localparam int COORD_BITS = 10;
  localparam int FRAC_BITS  = 16;
  localparam int MAX_SPAN   = 64;
  localparam int COLOR_BITS = 32;

  localparam int ACC_W   = COORD_BITS + FRAC_BITS;
  localparam int DIV_W   = ACC_W;
  localparam int SLOPE_W = FRAC_BITS + 1;
  localparam int CNT_W   = $clog2(MAX_SPAN + 1);
  localparam int STEP_W  = $clog2(DIV_W + 1);

  typedef struct packed {
    logic [COORD_BITS-1:0] x_start;
    logic [COORD_BITS-1:0] y_start;
    logic [COORD_BITS-1:0] x_end;
    logic [COORD_BITS-1:0] y_end;
    logic [COLOR_BITS-1:0] line_color;
  } line_req_t;

  typedef struct packed {
    logic [COORD_BITS-1:0] pixel_x;
    logic [COORD_BITS-1:0] pixel_y;
    logic [COLOR_BITS-1:0] pixel_color;
    logic                  last_pixel;
    logic                  truncated;
  } pixel_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SETUP,
    ST_DIVIDE,
    ST_EMIT
  } ctrl_state_t;

  typedef struct packed {
    logic load;
    logic div_start;
    logic emit;
  } dp_cmd_t;

  typedef struct packed {
    logic div_done;
    logic last;
  } dp_status_t;

endpackage

// File: hw/rtl/dlpg_div.sv
// ----------------------------------------------------------------------------
// DDA line pixel generator slope divider
// Restoring divider that retires one quotient bit per cycle.
// ----------------------------------------------------------------------------
module dlpg_div (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             start,
  input  logic [dlpg_pkg::DIV_W-1:0]       dividend,
  input  logic [dlpg_pkg::COORD_BITS-1:0]  divisor,
  output logic [dlpg_pkg::DIV_W-1:0]       quotient,
  output logic                             done
);

  logic [dlpg_pkg::DIV_W-1:0]      dvd;
  logic [dlpg_pkg::COORD_BITS:0]   rem;
  logic [dlpg_pkg::COORD_BITS-1:0] dsr;
  logic [dlpg_pkg::STEP_W-1:0]     steps;
  logic                            run;
  logic [dlpg_pkg::COORD_BITS:0]   rem_sh;
  logic                            qbit;

  always_comb begin
    rem_sh = {rem[dlpg_pkg::COORD_BITS-1:0], dvd[dlpg_pkg::DIV_W-1]};
    qbit   = (rem_sh >= {1'b0, dsr});
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      run   <= 1'b0;
      done  <= 1'b0;
      steps <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        run   <= 1'b1;
        steps <= dlpg_pkg::STEP_W'(dlpg_pkg::DIV_W);
      end else if (run) begin
        steps <= steps - 1'b1;
        if (steps == dlpg_pkg::STEP_W'(1)) begin
          run  <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      dvd <= dividend;
      dsr <= divisor;
      rem <= '0;
    end else if (run) begin
      rem <= qbit ? (rem_sh - {1'b0, dsr}) : rem_sh;
      dvd <= {dvd[dlpg_pkg::DIV_W-2:0], qbit};
    end
  end

  assign quotient = dvd;

endmodule

// File: hw/rtl/dlpg_datapath.sv
// ----------------------------------------------------------------------------
// DDA line pixel generator datapath
// Holds the line setup, runs the slope division and steps the major and
// minor coordinates, one pixel per emit command.
// ----------------------------------------------------------------------------
module dlpg_datapath (
  input  logic                  clk,
  input  logic                  rst,
  input  dlpg_pkg::line_req_t   req,
  input  dlpg_pkg::dp_cmd_t     cmd,
  output dlpg_pkg::dp_status_t  status,
  output dlpg_pkg::pixel_t      pixel,
  output logic                  pixel_valid
);

  localparam logic [dlpg_pkg::ACC_W:0] HALF = (dlpg_pkg::ACC_W + 1)'(1)
                                              << (dlpg_pkg::FRAC_BITS - 1);

  logic [dlpg_pkg::COORD_BITS-1:0] adx, ady, amaj_w, amin_w;
  logic                            major_is_y_w;
  logic                            trunc_w;
  logic [dlpg_pkg::CNT_W-1:0]      count_w;

  logic [dlpg_pkg::COORD_BITS-1:0] amaj, amin, maj;
  logic [dlpg_pkg::ACC_W-1:0]      minq;
  logic                            major_is_y, maj_down, min_down, trunc;
  logic [dlpg_pkg::COLOR_BITS-1:0] color;
  logic [dlpg_pkg::CNT_W-1:0]      remain;

  logic [dlpg_pkg::DIV_W-1:0]      quotient;
  logic                            div_done;
  logic [dlpg_pkg::ACC_W-1:0]      mag, slope;
  logic [dlpg_pkg::ACC_W:0]        rounded;
  logic [dlpg_pkg::COORD_BITS-1:0] minpix;
  logic                            last_w;

  dlpg_div u_div (
    .clk      (clk),
    .rst      (rst),
    .start    (cmd.div_start),
    .dividend ({amin, dlpg_pkg::FRAC_BITS'(0)}),
    .divisor  (amaj),
    .quotient (quotient),
    .done     (div_done)
  );

  always_comb begin
    adx = (req.x_end >= req.x_start) ? req.x_end - req.x_start : req.x_start - req.x_end;
    ady = (req.y_end >= req.y_start) ? req.y_end - req.y_start : req.y_start - req.y_end;
    major_is_y_w = (ady > adx);
    amaj_w = major_is_y_w ? ady : adx;
    amin_w = major_is_y_w ? adx : ady;
    trunc_w = (32'(amaj_w) > 32'(dlpg_pkg::MAX_SPAN));
    if (trunc_w) begin
      count_w = dlpg_pkg::CNT_W'(dlpg_pkg::MAX_SPAN);
    end else if (amaj_w == '0) begin
      count_w = dlpg_pkg::CNT_W'(1);
    end else begin
      count_w = dlpg_pkg::CNT_W'(amaj_w);
    end
  end

  always_comb begin
    mag     = (amaj == '0) ? '0 : dlpg_pkg::ACC_W'(quotient[dlpg_pkg::SLOPE_W-1:0]);
    slope   = min_down ? (~mag + 1'b1) : mag;
    rounded = {1'b0, minq} + HALF;
    minpix  = rounded[dlpg_pkg::ACC_W-1:dlpg_pkg::FRAC_BITS];
    last_w  = (remain == dlpg_pkg::CNT_W'(1));
  end

  assign status = '{div_done: div_done, last: last_w};

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      major_is_y <= major_is_y_w;
      amaj       <= amaj_w;
      amin       <= amin_w;
      trunc      <= trunc_w;
      remain     <= count_w;
      color      <= req.line_color;
      if (major_is_y_w) begin
        maj      <= req.y_start;
        maj_down <= (req.y_end < req.y_start);
        min_down <= (req.x_end < req.x_start);
        minq     <= {req.x_start, dlpg_pkg::FRAC_BITS'(0)};
      end else begin
        maj      <= req.x_start;
        maj_down <= (req.x_end < req.x_start);
        min_down <= (req.y_end < req.y_start);
        minq     <= {req.y_start, dlpg_pkg::FRAC_BITS'(0)};
      end
    end else if (cmd.emit) begin
      maj    <= maj_down ? maj - 1'b1 : maj + 1'b1;
      minq   <= minq + slope;
      remain <= remain - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.emit) begin
      pixel.pixel_x     <= major_is_y ? minpix : maj;
      pixel.pixel_y     <= major_is_y ? maj : minpix;
      pixel.pixel_color <= color;
      pixel.last_pixel  <= last_w;
      pixel.truncated   <= last_w & trunc;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      pixel_valid <= 1'b0;
    end else begin
      pixel_valid <= cmd.emit;
    end
  end

endmodule

// File: hw/rtl/dlpg_ctrl.sv
// ----------------------------------------------------------------------------
// DDA line pixel generator controller
// Sequences setup, slope division and pixel emission for one line.
// ----------------------------------------------------------------------------
module dlpg_ctrl (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  start,
  input  dlpg_pkg::dp_status_t  status,
  output dlpg_pkg::dp_cmd_t     cmd,
  output logic                  busy
);

  dlpg_pkg::ctrl_state_t state, state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= dlpg_pkg::ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    case (state)
      dlpg_pkg::ST_IDLE: begin
        if (start) state_next = dlpg_pkg::ST_SETUP;
      end
      dlpg_pkg::ST_SETUP: begin
        state_next = dlpg_pkg::ST_DIVIDE;
      end
      dlpg_pkg::ST_DIVIDE: begin
        if (status.div_done) state_next = dlpg_pkg::ST_EMIT;
      end
      dlpg_pkg::ST_EMIT: begin
        if (status.last) state_next = dlpg_pkg::ST_IDLE;
      end
      default: begin
        state_next = dlpg_pkg::ST_IDLE;
      end
    endcase
  end

  always_comb begin
    cmd  = '0;
    busy = 1'b1;
    case (state)
      dlpg_pkg::ST_IDLE: begin
        busy     = 1'b0;
        cmd.load = start;
      end
      dlpg_pkg::ST_SETUP: begin
        cmd.div_start = 1'b1;
      end
      dlpg_pkg::ST_DIVIDE: begin
        cmd = '0;
      end
      dlpg_pkg::ST_EMIT: begin
        cmd.emit = 1'b1;
      end
      default: begin
        cmd = '0;
      end
    endcase
  end

endmodule

// File: hw/rtl/dda_line_pixel_generator_top.sv
// ----------------------------------------------------------------------------
// DDA line pixel generator
// A line request enters on req when start is high and busy is low. The block
// then emits the line's pixels on pixel, one per cycle, each marked by a
// one-cycle pixel_valid strobe; the last pixel carries last_pixel, and
// truncated when the major span was longer than the maximum span.
// The first pixel follows the request through a setup state, then the slope
// divider, which retires one quotient bit per cycle, then a hand-off to the
// emit state. A line of N pixels (1 to 64) holds busy high until its last
// pixel is emitted; that pixel is shown in the first cycle with busy low,
// so the next request can be taken while that last pixel is shown.
// The receiver cannot stall: every pixel is shown for exactly one cycle.
// Reset returns the controller to idle and drops pixel_valid; a line that
// was in progress is abandoned.
// ----------------------------------------------------------------------------
module dda_line_pixel_generator_top (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 start,
  output logic                 busy,
  input  dlpg_pkg::line_req_t  req,
  output logic                 pixel_valid,
  output dlpg_pkg::pixel_t     pixel
);

  dlpg_pkg::dp_cmd_t    cmd;
  dlpg_pkg::dp_status_t status;

  dlpg_ctrl u_ctrl (
    .clk    (clk),
    .rst    (rst),
    .start  (start),
    .status (status),
    .cmd    (cmd),
    .busy   (busy)
  );

  dlpg_datapath u_datapath (
    .clk         (clk),
    .rst         (rst),
    .req         (req),
    .cmd         (cmd),
    .status      (status),
    .pixel       (pixel),
    .pixel_valid (pixel_valid)
  );

endmodule
